// ----- src/imu_ste_pkg.sv -----
// Shared types, constants and trim tables for the IMU self-test evaluator.
package imu_ste_pkg;

  localparam int AXES         = 6;
  localparam int ACCEL_AXES   = 3;
  localparam int AXIS_W       = $clog2(AXES);
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 22;
  localparam int ACC_W        = 36;
  localparam int CODE_W       = 5;
  localparam int TABLE_W      = 16;
  localparam int TRIM_MAG_W   = 24;
  localparam int TRIM_W       = TRIM_MAG_W + 1;
  localparam int TRIM7_W      = TRIM_MAG_W + 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [AXIS_W-1:0] AXIS_LAST   = AXIS_W'(AXES - 1);
  localparam logic [AXIS_W-1:0] AXIS_GYRO_Y = AXIS_W'(4);

  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(2 ** (SUM_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SUM_MIN = -(ACC_W'(2 ** (SUM_W - 1)));

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_TEST     = 2'd1,
    MODE_EVALUATE = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRIM_X         = 2'd0,
    CFG_TRIM_Y         = 2'd1,
    CFG_TRIM_Z         = 2'd2,
    CFG_TRIM_ACCEL_LOW = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    OP_SATADD,
    OP_SUB,
    OP_MUL50_SUB,
    OP_ABS
  } alu_op_e;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0] accel_fail_axes;
    logic [2:0] gyro_fail_axes;
    logic [1:0] verdict;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] trim_x_byte;
    logic [CFG_DATA_W-1:0] trim_y_byte;
    logic [CFG_DATA_W-1:0] trim_z_byte;
    logic [CFG_DATA_W-1:0] trim_accel_low_byte;
  } trim_cfg_t;

  typedef struct packed {
    logic signed [TRIM_W-1:0] trim;
    logic [TRIM7_W-1:0]       trim7;
  } trim_t;

  localparam logic [TABLE_W-1:0] ACCEL_TRIM_TABLE [32] = '{
    16'd1347, 16'd1393, 16'd1440, 16'd1488, 16'd1538, 16'd1590, 16'd1644, 16'd1699,
    16'd1757, 16'd1816, 16'd1877, 16'd1941, 16'd2006, 16'd2074, 16'd2144, 16'd2216,
    16'd2291, 16'd2368, 16'd2448, 16'd2531, 16'd2616, 16'd2704, 16'd2795, 16'd2890,
    16'd2987, 16'd3088, 16'd3192, 16'd3300, 16'd3411, 16'd3526, 16'd3645, 16'd3768
  };

  localparam logic [TABLE_W-1:0] GYRO_TRIM_TABLE [32] = '{
    16'd3131, 16'd3275, 16'd3426, 16'd3583, 16'd3748, 16'd3920, 16'd4101, 16'd4289,
    16'd4487, 16'd4693, 16'd4909, 16'd5135, 16'd5371, 16'd5618, 16'd5877, 16'd6147,
    16'd6430, 16'd6725, 16'd7035, 16'd7358, 16'd7697, 16'd8051, 16'd8421, 16'd8809,
    16'd9214, 16'd9638, 16'd10081, 16'd10545, 16'd11030, 16'd11537, 16'd12068, 16'd12623
  };

endpackage

// ----- src/imu_ste_trim.sv -----
// Trim decoder: factory code extraction, table lookup and scaling for one axis.
module imu_ste_trim (
  input  imu_ste_pkg::trim_cfg_t             cfg_i,
  input  logic [imu_ste_pkg::AXIS_W-1:0]     axis_i,
  output imu_ste_pkg::trim_t                 trim_o
);

  logic [imu_ste_pkg::CODE_W-1:0]     code;
  logic [1:0]                         low_bits;
  logic [imu_ste_pkg::CFG_DATA_W-1:0] axis_byte;
  logic                               is_gyro;
  logic [imu_ste_pkg::TABLE_W-1:0]    base;
  logic [imu_ste_pkg::TRIM_MAG_W-1:0] base_ext;
  logic [imu_ste_pkg::TRIM_MAG_W-1:0] mag;
  logic [imu_ste_pkg::TRIM7_W-1:0]    mag_ext;

  always_comb begin
    is_gyro = (axis_i >= imu_ste_pkg::AXIS_W'(imu_ste_pkg::ACCEL_AXES));
    unique case (is_gyro ? axis_i - imu_ste_pkg::AXIS_W'(imu_ste_pkg::ACCEL_AXES) : axis_i)
      imu_ste_pkg::AXIS_W'(0): begin
        axis_byte = cfg_i.trim_x_byte;
        low_bits  = cfg_i.trim_accel_low_byte[5:4];
      end
      imu_ste_pkg::AXIS_W'(1): begin
        axis_byte = cfg_i.trim_y_byte;
        low_bits  = cfg_i.trim_accel_low_byte[3:2];
      end
      imu_ste_pkg::AXIS_W'(2): begin
        axis_byte = cfg_i.trim_z_byte;
        low_bits  = cfg_i.trim_accel_low_byte[1:0];
      end
      default: begin
        axis_byte = '0;
        low_bits  = '0;
      end
    endcase
    code     = is_gyro ? axis_byte[4:0] : {axis_byte[7:5], low_bits};
    base     = is_gyro ? imu_ste_pkg::GYRO_TRIM_TABLE[code]
                       : imu_ste_pkg::ACCEL_TRIM_TABLE[code];
    base_ext = imu_ste_pkg::TRIM_MAG_W'(base);
    // Times 1000 as 1024 - 16 - 8.
    mag      = (base_ext << 10) - (base_ext << 4) - (base_ext << 3);
    mag_ext  = imu_ste_pkg::TRIM7_W'(mag);
    trim_o.trim7 = (mag_ext << 3) - mag_ext;
    if (axis_i == imu_ste_pkg::AXIS_GYRO_Y) begin
      trim_o.trim = -$signed(imu_ste_pkg::TRIM_W'(mag));
    end else begin
      trim_o.trim = $signed(imu_ste_pkg::TRIM_W'(mag));
    end
  end

endmodule

// ----- src/imu_ste_alu.sv -----
// Shared arithmetic unit: saturating add, subtract, times-fifty-minus and absolute value.
module imu_ste_alu (
  input  imu_ste_pkg::alu_op_e                   op_i,
  input  logic signed [imu_ste_pkg::ACC_W-1:0]   a_i,
  input  logic signed [imu_ste_pkg::ACC_W-1:0]   b_i,
  output logic signed [imu_ste_pkg::ACC_W-1:0]   res_o
);

  logic signed [imu_ste_pkg::ACC_W-1:0] sum;
  logic signed [imu_ste_pkg::ACC_W-1:0] prod50;

  always_comb begin
    sum    = a_i + b_i;
    prod50 = (a_i <<< 5) + (a_i <<< 4) + (a_i <<< 1);
    unique case (op_i)
      imu_ste_pkg::OP_SATADD: begin
        if (sum > imu_ste_pkg::SUM_MAX) begin
          res_o = imu_ste_pkg::SUM_MAX;
        end else if (sum < imu_ste_pkg::SUM_MIN) begin
          res_o = imu_ste_pkg::SUM_MIN;
        end else begin
          res_o = sum;
        end
      end
      imu_ste_pkg::OP_SUB:       res_o = a_i - b_i;
      imu_ste_pkg::OP_MUL50_SUB: res_o = prod50 - b_i;
      imu_ste_pkg::OP_ABS:       res_o = a_i[imu_ste_pkg::ACC_W-1] ? -a_i : a_i;
      default:                   res_o = '0;
    endcase
  end

endmodule

// ----- src/imu_self_test_evaluator.sv -----
// Top level of the IMU self-test evaluator: sequencer, accumulators and config registers.
//
//   Channel | Direction | Handshake             | Payload
//   in      | input     | in_valid_i/in_ready_o | in_i (mode and six samples)
//   out     | output    | out_valid_o/out_ready_i | out_o (fail masks and verdict)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample item is accepted and then goes one axis at a time through the shared adder.
// An evaluate item takes four shared-unit steps per axis, then waits in S_OUT for the output.
// An item with the unused mode is accepted and dropped.
// Reset clears the sums, trims and control state at once; the output register lets the
// next item be accepted while a result waits, and a second result waits until it drains.
module imu_self_test_evaluator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  imu_ste_pkg::in_item_t                  in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output imu_ste_pkg::out_item_t                 out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [imu_ste_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [imu_ste_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIFF,
    S_RESP,
    S_ABS,
    S_CMP,
    S_OUT
  } state_e;

  state_e                                   state_q;
  logic [imu_ste_pkg::AXIS_W-1:0]           axis_q;
  logic                                     test_set_q;
  imu_ste_pkg::in_item_t                    item_q;
  logic signed [imu_ste_pkg::ACC_W-1:0]     acc_q;
  imu_ste_pkg::trim_t                       trim_q;
  logic [imu_ste_pkg::AXES-1:0]             fail_q;
  logic                                     out_valid_q;
  imu_ste_pkg::out_item_t                   out_q;
  imu_ste_pkg::trim_cfg_t                   cfg_q;
  logic signed [imu_ste_pkg::SUM_W-1:0]     normal_q [imu_ste_pkg::AXES];
  logic signed [imu_ste_pkg::SUM_W-1:0]     test_q [imu_ste_pkg::AXES];

  logic signed [imu_ste_pkg::SAMPLE_W-1:0]  sample [imu_ste_pkg::AXES];
  logic signed [imu_ste_pkg::SUM_W-1:0]     normal_rd;
  logic signed [imu_ste_pkg::SUM_W-1:0]     test_rd;
  imu_ste_pkg::trim_t                       trim_d;
  imu_ste_pkg::alu_op_e                     alu_op;
  logic signed [imu_ste_pkg::ACC_W-1:0]     alu_a;
  logic signed [imu_ste_pkg::ACC_W-1:0]     alu_b;
  logic signed [imu_ste_pkg::ACC_W-1:0]     alu_res;
  logic                                     axis_fail;
  logic                                     out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    sample[0] = item_q.accel_x;
    sample[1] = item_q.accel_y;
    sample[2] = item_q.accel_z;
    sample[3] = item_q.gyro_x;
    sample[4] = item_q.gyro_y;
    sample[5] = item_q.gyro_z;
  end

  assign normal_rd = normal_q[axis_q];
  assign test_rd   = test_q[axis_q];

  imu_ste_trim u_trim (
    .cfg_i  (cfg_q),
    .axis_i (axis_q),
    .trim_o (trim_d)
  );

  always_comb begin
    alu_op = imu_ste_pkg::OP_SATADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_ACC: begin
        alu_op = imu_ste_pkg::OP_SATADD;
        alu_a  = imu_ste_pkg::ACC_W'(test_set_q ? test_rd : normal_rd);
        alu_b  = imu_ste_pkg::ACC_W'(sample[axis_q]);
      end
      S_DIFF: begin
        alu_op = imu_ste_pkg::OP_SUB;
        alu_a  = imu_ste_pkg::ACC_W'(test_rd);
        alu_b  = imu_ste_pkg::ACC_W'(normal_rd);
      end
      S_RESP: begin
        alu_op = imu_ste_pkg::OP_MUL50_SUB;
        alu_a  = acc_q;
        alu_b  = imu_ste_pkg::ACC_W'(trim_q.trim);
      end
      S_ABS: begin
        alu_op = imu_ste_pkg::OP_ABS;
        alu_a  = acc_q;
      end
      S_CMP: begin
        alu_op = imu_ste_pkg::OP_MUL50_SUB;
        alu_a  = acc_q;
        alu_b  = $signed(imu_ste_pkg::ACC_W'(trim_q.trim7));
      end
      default: begin
        alu_op = imu_ste_pkg::OP_SATADD;
      end
    endcase
  end

  imu_ste_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign axis_fail = !alu_res[imu_ste_pkg::ACC_W-1] && (alu_res != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (imu_ste_pkg::cfg_index_e'(cfg_index_i))
        imu_ste_pkg::CFG_TRIM_X:         cfg_q.trim_x_byte         <= cfg_data_i;
        imu_ste_pkg::CFG_TRIM_Y:         cfg_q.trim_y_byte         <= cfg_data_i;
        imu_ste_pkg::CFG_TRIM_Z:         cfg_q.trim_z_byte         <= cfg_data_i;
        imu_ste_pkg::CFG_TRIM_ACCEL_LOW: cfg_q.trim_accel_low_byte <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      test_set_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fail_q      <= '0;
      item_q      <= '0;
      acc_q       <= '0;
      trim_q      <= '0;
      out_q       <= '0;
      for (int i = 0; i < imu_ste_pkg::AXES; i++) begin
        normal_q[i] <= '0;
        test_q[i]   <= '0;
      end
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          axis_q <= '0;
          if (in_valid_i) begin
            item_q     <= in_i;
            test_set_q <= (in_i.mode == imu_ste_pkg::MODE_TEST);
            if (in_i.mode == imu_ste_pkg::MODE_NORMAL || in_i.mode == imu_ste_pkg::MODE_TEST) begin
              state_q <= S_ACC;
            end else if (in_i.mode == imu_ste_pkg::MODE_EVALUATE) begin
              state_q <= S_DIFF;
            end
          end
        end
        S_ACC: begin
          if (test_set_q) begin
            test_q[axis_q] <= alu_res[imu_ste_pkg::SUM_W-1:0];
          end else begin
            normal_q[axis_q] <= alu_res[imu_ste_pkg::SUM_W-1:0];
          end
          if (axis_q == imu_ste_pkg::AXIS_LAST) begin
            state_q <= S_IDLE;
          end else begin
            axis_q <= axis_q + 1'b1;
          end
        end
        S_DIFF: begin
          acc_q   <= alu_res;
          trim_q  <= trim_d;
          state_q <= S_RESP;
        end
        S_RESP: begin
          acc_q   <= alu_res;
          state_q <= S_ABS;
        end
        S_ABS: begin
          acc_q   <= alu_res;
          state_q <= S_CMP;
        end
        S_CMP: begin
          fail_q[axis_q] <= axis_fail;
          if (axis_q == imu_ste_pkg::AXIS_LAST) begin
            state_q <= S_OUT;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= S_DIFF;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q.accel_fail_axes     <= fail_q[2:0];
            out_q.gyro_fail_axes      <= fail_q[5:3];
            out_q.verdict             <= {|fail_q[5:3], |fail_q[2:0]};
            for (int i = 0; i < imu_ste_pkg::AXES; i++) begin
              normal_q[i] <= '0;
              test_q[i]   <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("Result appeared without a finished evaluation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (normal_q[0] == '0 && test_q[0] == '0 &&
                                        normal_q[5] == '0 && test_q[5] == '0))
    else $error("Sums were not cleared after an evaluation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.verdict[0] == |out_o.accel_fail_axes &&
                     out_o.verdict[1] == |out_o.gyro_fail_axes))
    else $error("Verdict does not match the fail masks.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC || state_q == S_CMP) |-> (axis_q <= imu_ste_pkg::AXIS_LAST))
    else $error("Axis counter ran past the last axis.");

endmodule
